### rtl/core/bgss_pkg.sv
// ----------------------------------------------------------------------------
// bgss_pkg: shared types and constants of the beat grid step sequencer
// Payload structs, configuration register map, codes and the exp table.
// ----------------------------------------------------------------------------
package bgss_pkg;

  localparam int unsigned Steps       = 16;
  localparam int unsigned StepW       = 4;
  localparam int unsigned PosW        = 40;
  localparam int unsigned PosFrac     = 16;
  localparam int unsigned GainFrac    = 16;
  localparam int unsigned GainW       = GainFrac + 1;
  localparam logic [GainW-1:0] GainOne = GainW'(1) << GainFrac;
  localparam int unsigned DtW         = 20;
  localparam int unsigned TempoW      = 24;
  localparam logic [TempoW-1:0] MinTempo = TempoW'(256);

  // divider: numerator dt << 16, denominator tau * 1000, quotient below 16.0 in Q16
  localparam int unsigned NumW        = DtW + 16;
  localparam int unsigned DenW        = 26;
  localparam int unsigned XW          = 20;
  localparam int unsigned DsrW        = DenW + XW;
  localparam int unsigned KW          = $clog2(XW + 1);

  // exponential table, Q30
  localparam int unsigned ExpDepth    = 256;
  localparam int unsigned IdxW        = $clog2(ExpDepth);
  localparam int unsigned AddrW       = IdxW + 1;
  localparam int unsigned ExpW        = 31;
  localparam int unsigned EShift      = 30 - GainFrac;
  localparam longint unsigned Q30One  = 64'd1 << 30;
  localparam longint unsigned ExpStep = (64'd16 << 30) / ExpDepth;

  localparam int unsigned MulW        = 32;

  // beat modes
  localparam logic [1:0] ModeSnap     = 2'd0;
  localparam logic [1:0] ModeGlide    = 2'd1;
  localparam logic [1:0] ModeTeleport = 2'd2;

  // step actions
  localparam logic [1:0] ActHold      = 2'd0;
  localparam logic [1:0] ActAdvance   = 2'd1;
  localparam logic [1:0] ActJump      = 2'd2;

  // grid divisions
  localparam logic [2:0] GridWhole     = 3'd0;
  localparam logic [2:0] GridHalf      = 3'd1;
  localparam logic [2:0] GridQuarter   = 3'd2;
  localparam logic [2:0] GridEighth    = 3'd3;
  localparam logic [2:0] GridSixteenth = 3'd4;

  typedef enum logic [2:0] {
    CfgBeatMode       = 3'd0,
    CfgGridDivision   = 3'd1,
    CfgDecayMs        = 3'd2,
    CfgDipGain        = 3'd3,
    CfgPatternActions = 3'd4,
    CfgPatternTargets = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PosW-1:0] ppq_position;
    logic [TempoW-1:0]      tempo_bpm;
    logic                   is_playing;
    logic [DtW-1:0]         dt_us;
  } in_item_t;

  typedef struct packed {
    logic [StepW-1:0] step_index;
    logic [GainW-1:0] gain;
    logic             beat_fired;
    logic             morph_advance;
    logic             morph_jump;
    logic [StepW-1:0] jump_slot;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  beat_mode;
    logic [2:0]  grid_division;
    logic [15:0] decay_ms;
    logic [16:0] dip_gain;
    logic [31:0] pattern_actions;
    logic [63:0] pattern_targets;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [XW-1:0]    quot;
  } div_res_t;

  typedef struct packed {
    logic             beat;
    logic             adv;
    logic             jmp;
    logic [StepW-1:0] slot;
    logic [StepW-1:0] step;
  } beat_res_t;

  typedef logic [ExpW-1:0] exp_rom_t [0:ExpDepth];

  // quotient of a small constant division, by shift and subtract
  function automatic longint unsigned div_small(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-16 i / depth) in Q30, each entry the previous times one step ratio
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    longint unsigned d;
    longint unsigned term;
    longint unsigned pos_sum;
    longint unsigned neg_sum;
    longint unsigned r;
    longint unsigned prev;
    d       = ExpStep;
    term    = Q30One;
    pos_sum = Q30One;
    neg_sum = 64'd0;
    for (int k = 1; k <= 24; k++) begin
      term = div_small((term * d) >> 30, 64'(k));
      if (k[0]) neg_sum = neg_sum + term;
      else pos_sum = pos_sum + term;
    end
    r      = pos_sum - neg_sum;
    prev   = Q30One;
    rom[0] = ExpW'(Q30One);
    for (int i = 1; i <= ExpDepth; i++) begin
      prev   = (prev * r + (64'd1 << 29)) >> 30;
      rom[i] = ExpW'(prev);
    end
    return rom;
  endfunction

  localparam exp_rom_t ExpRom = build_exp_rom();

endpackage

### rtl/core/beat_grid_step_sequencer_top.sv
// ----------------------------------------------------------------------------
// beat_grid_step_sequencer_top: beat grid step sequencer with gain envelope
// Flow: the 21-step serial divider, two table reads, the interpolation product,
//   alpha and the envelope product; when dt/tau reaches 16, alpha saturates
//   and the table and interpolation steps are skipped. No new tick while busy.
// Reset: registers at their defaults, no position history, step 0, unity gain.
// ----------------------------------------------------------------------------
module beat_grid_step_sequencer_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bgss_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bgss_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i
);
  import bgss_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StDiv   = 8'b0000_0010,
    StRdA   = 8'b0000_0100,
    StRdB   = 8'b0000_1000,
    StMulE  = 8'b0001_0000,
    StAlpha = 8'b0010_0000,
    StMulG  = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  cfg_t              cfg_q;
  in_item_t          item_q;
  logic [GainW-1:0]  env_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [IdxW-1:0]   idx_q;
  logic [XW-1:0]     frac_q;
  logic [ExpW-1:0]   ta_q, tb_q;
  logic [GainW-1:0]  alpha_q;

  logic              in_fire;
  logic              div_start;
  div_res_t          div_res;
  logic              mul_en;
  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] mul_p;
  logic              commit;
  beat_res_t         beat_res;

  logic [AddrW-1:0]  rom_addr;
  logic [ExpW-1:0]   rom_data;
  logic [ExpW-1:0]   diff;
  logic [ExpW-1:0]   e30;
  logic [31:0]       e_round;
  logic [GainW-1:0]  e_val;
  logic [GainW-1:0]  gain_add;
  logic [GainW:0]    gain_sum;
  logic [GainW-1:0]  gain_new;
  logic [GainW-1:0]  dip;
  logic [GainW-1:0]  env_next;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign div_start   = in_fire;
  assign commit      = (state_q == StDone) && (!out_valid_q || out_ready_i);

  bgss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dt_i    (in_data_i.dt_us),
    .decay_i (cfg_q.decay_ms),
    .res_o   (div_res)
  );

  bgss_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  bgss_beat u_beat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .res_o    (beat_res)
  );

  // table read: lower entry first, upper entry the cycle after
  assign rom_addr = (state_q == StRdB) ? {1'b0, idx_q} + AddrW'(1) : {1'b0, idx_q};
  assign rom_data = ExpRom[rom_addr];

  assign diff = (ta_q > tb_q) ? ta_q - tb_q : '0;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = MulW'(diff);
    mul_b  = MulW'(frac_q);
    unique case (state_q)
      StMulE: mul_en = 1'b1;
      StMulG: begin
        mul_en = 1'b1;
        mul_a  = MulW'(GainOne - env_q);
        mul_b  = MulW'(alpha_q);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // interpolated exponential, rounded half up to the gain format
  assign e30     = ta_q - ExpW'(mul_p >> XW);
  assign e_round = (32'(e30) + (32'd1 << (EShift - 1))) >> EShift;
  assign e_val   = (e_round > 32'(GainOne)) ? GainOne : GainW'(e_round);

  // envelope relaxes toward unity; teleport snaps it to the dip level on a beat
  assign gain_add = mul_p[GainFrac +: GainW];
  assign gain_sum = {1'b0, env_q} + {1'b0, gain_add};
  assign gain_new = (gain_sum > {1'b0, GainOne}) ? GainOne : gain_sum[GainW-1:0];
  assign dip      = (cfg_q.dip_gain > GainOne) ? GainOne : cfg_q.dip_gain;
  assign env_next = (beat_res.beat && (cfg_q.beat_mode == ModeTeleport)) ? dip : gain_new;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_fire) state_d = StDiv;
      StDiv: begin
        if (div_res.done) state_d = div_res.sat ? StMulG : StRdA;
      end
      StRdA:   state_d = StRdB;
      StRdB:   state_d = StMulE;
      StMulE:  state_d = StAlpha;
      StAlpha: state_d = StMulG;
      StMulG:  state_d = StDone;
      StDone:  if (commit) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= StIdle;
      cfg_q.beat_mode     <= ModeSnap;
      cfg_q.grid_division <= GridQuarter;
      cfg_q.decay_ms      <= 16'd100;
      cfg_q.dip_gain      <= 17'd65536;
      cfg_q.pattern_actions <= '0;
      cfg_q.pattern_targets <= '0;
      env_q               <= GainOne;
      out_valid_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CfgBeatMode:       cfg_q.beat_mode       <= cfg_data_i[1:0];
          CfgGridDivision:   cfg_q.grid_division   <= cfg_data_i[2:0];
          CfgDecayMs:        cfg_q.decay_ms        <= cfg_data_i[15:0];
          CfgDipGain:        cfg_q.dip_gain        <= cfg_data_i[16:0];
          CfgPatternActions: cfg_q.pattern_actions <= cfg_data_i[31:0];
          CfgPatternTargets: cfg_q.pattern_targets <= cfg_data_i;
          default: ;
        endcase
      end
      if (commit) begin
        env_q       <= env_next;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= in_data_i;
    if ((state_q == StDiv) && div_res.done) begin
      idx_q   <= div_res.quot[XW-1 -: IdxW];
      frac_q  <= {div_res.quot[XW-IdxW-1:0], IdxW'(0)};
      alpha_q <= GainOne;
    end
    if (state_q == StRdA) ta_q <= rom_data;
    if (state_q == StRdB) tb_q <= rom_data;
    if (state_q == StAlpha) alpha_q <= GainOne - e_val;
    if (commit) begin
      out_q.step_index    <= beat_res.step;
      out_q.gain          <= env_next;
      out_q.beat_fired    <= beat_res.beat;
      out_q.morph_advance <= beat_res.adv;
      out_q.morph_jump    <= beat_res.jmp;
      out_q.jump_slot     <= beat_res.slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/bgss_div.sv
// ----------------------------------------------------------------------------
// bgss_div: restoring divider for the envelope time ratio
// One compare and subtract a cycle; saturates once the quotient reaches 16.0.
// ----------------------------------------------------------------------------
module bgss_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bgss_pkg::DtW-1:0]   dt_i,
  input  logic [15:0]                decay_i,
  output bgss_pkg::div_res_t         res_o
);
  import bgss_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            sat_q, sat_d;
  logic [KW-1:0]   k_q, k_d;
  logic [NumW-1:0] rem_q, rem_d;
  logic [DsrW-1:0] dsr_q, dsr_d;
  logic [XW-1:0]   quot_q, quot_d;

  logic [15:0]     tau;
  logic [DenW-1:0] den;
  logic            ge;

  assign tau = (decay_i == 16'd0) ? 16'd1 : decay_i;
  assign den = DenW'(tau) * DenW'(1000);
  assign ge  = {{(DsrW-NumW){1'b0}}, rem_q} >= dsr_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    k_d    = k_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      sat_d  = 1'b0;
      k_d    = KW'(XW);
      rem_d  = {dt_i, 16'd0};
      dsr_d  = {den, XW'(0)};
      quot_d = '0;
    end else if (busy_q) begin
      if (k_q == KW'(XW)) begin
        // top quotient bit set means x is at least 16.0: alpha is unity
        if (ge) begin
          sat_d  = 1'b1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        if (ge) rem_d = rem_q - dsr_q[NumW-1:0];
        quot_d = {quot_q[XW-2:0], ge};
        if (k_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
      dsr_d = dsr_q >> 1;
      k_d   = k_q - KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sat_q  <= sat_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.quot = quot_q;

endmodule

### rtl/core/bgss_mul.sv
// ----------------------------------------------------------------------------
// bgss_mul: shared registered multiplier
// Serves the table interpolation and the envelope update in turn.
// ----------------------------------------------------------------------------
module bgss_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [bgss_pkg::MulW-1:0]   a_i,
  input  logic [bgss_pkg::MulW-1:0]   b_i,
  output logic [2*bgss_pkg::MulW-1:0] p_o
);
  import bgss_pkg::*;

  logic [2*MulW-1:0] p_q;

  // hold the product until the next operand pair is loaded
  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= (2*MulW)'(a_i) * (2*MulW)'(b_i);
  end

  assign p_o = p_q;

endmodule

### rtl/core/bgss_beat.sv
// ----------------------------------------------------------------------------
// bgss_beat: grid crossing detector and step pattern sequencer
// Keeps position history and the step counter; updates on commit.
// ----------------------------------------------------------------------------
module bgss_beat (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  commit_i,
  input  bgss_pkg::cfg_t        cfg_i,
  input  bgss_pkg::in_item_t    item_i,
  output bgss_pkg::beat_res_t   res_o
);
  import bgss_pkg::*;

  logic signed [PosW-1:0] last_q;
  logic                   valid_q;
  logic [StepW-1:0]       step_q, step_d;

  logic                   run;
  logic                   beat;
  logic [1:0]             act;
  logic [StepW-1:0]       tgt;
  logic [StepW-1:0]       slot;

  function automatic logic signed [PosW-1:0] grid_floor(logic signed [PosW-1:0] p,
                                                        logic [2:0] g);
    logic signed [PosW-1:0] f;
    unique case (g)
      GridWhole:     f = p >>> (PosFrac + 2);
      GridHalf:      f = p >>> (PosFrac + 1);
      GridEighth:    f = p >>> (PosFrac - 1);
      GridSixteenth: f = p >>> (PosFrac - 2);
      default:       f = p >>> PosFrac;
    endcase
    return f;
  endfunction

  assign run  = item_i.is_playing && (item_i.tempo_bpm >= MinTempo) &&
                (item_i.dt_us != '0);
  assign beat = run && valid_q && (item_i.ppq_position >= last_q) &&
                (grid_floor(item_i.ppq_position, cfg_i.grid_division) >
                 grid_floor(last_q, cfg_i.grid_division));

  assign act = cfg_i.pattern_actions[{step_q, 1'b0} +: 2];
  assign tgt = cfg_i.pattern_targets[{step_q, 2'b00} +: StepW];

  always_comb begin
    slot = '0;
    if (beat && (act == ActJump)) begin
      slot = (32'(tgt) > Steps - 1) ? StepW'(Steps - 1) : tgt;
    end
  end

  always_comb begin
    step_d = step_q;
    if (beat) begin
      step_d = (32'(step_q) == Steps - 1) ? '0 : step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      valid_q <= 1'b0;
      step_q  <= '0;
    end else if (commit_i) begin
      if (!run) begin
        valid_q <= 1'b0;
      end else begin
        last_q  <= item_i.ppq_position;
        valid_q <= 1'b1;
      end
      step_q <= step_d;
    end
  end

  assign res_o.beat = beat;
  assign res_o.adv  = beat && (act == ActAdvance);
  assign res_o.jmp  = beat && (act == ActJump);
  assign res_o.slot = slot;
  assign res_o.step = step_d;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the beat grid step sequencer
// Ticks go in over a valid/ready channel, and each result is checked against
// a cycle-free predictor of the envelope, the beat grid and the step pattern.
// A directed part covers the corner cases. Random phases follow, built mostly
// from advancing transport runs, and each phase has its own register
// setting and its own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import bgss_pkg::*;

  localparam int unsigned TableDepth = 256;
  localparam longint      QN         = 65536;
  localparam longint      PosMin     = -(longint'(1) << 39);
  localparam logic [39:0] PosBias    = 40'h80_0000_0000;
  localparam int unsigned TailCycles = 40;

  localparam logic [1:0] ModeSpare    = 2'd3;
  localparam logic [1:0] ActSpare     = 2'd3;
  localparam logic [2:0] GridSpare    = 3'd7;
  localparam logic [23:0] TempoNormal = 24'd30720;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  in_item_t    in_data     = '0;
  logic        out_ready   = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic [2:0]  cfg_index   = '0;
  logic [63:0] cfg_data    = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  out_item_t   out_data_o;
  logic        cfg_ready_o;

  // predictor state
  longint unsigned exp_q30 [0:TableDepth];
  cfg_t            cfg_model;
  logic [39:0]     hist_pos;
  bit              hist_valid;
  logic [3:0]      step_ctr;
  logic [16:0]     env_gain;

  out_item_t         expected_q [$];
  logic signed [39:0] walk_pos;
  int unsigned       sender_idle_pct = 0;
  int unsigned       rcv_stall_pct   = 0;
  int unsigned       error_count     = 0;
  int unsigned       ticks_sent      = 0;
  int unsigned       results_checked = 0;
  int unsigned       beats_seen      = 0;
  int unsigned       advances_seen   = 0;
  int unsigned       jumps_seen      = 0;

  beat_grid_step_sequencer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // exp(-16 i / depth) in Q30: a truncated Taylor ratio applied repeatedly
  function automatic void fill_exp_table();
    longint unsigned dstep, term, plus, minus, ratio;
    dstep = (64'd16 << 30) / TableDepth;
    term  = 64'd1 << 30;
    plus  = 64'd1 << 30;
    minus = 0;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * dstep) >> 30) / k;
      if (k % 2 == 1) minus += term;
      else plus += term;
    end
    ratio = plus - minus;
    exp_q30[0] = 64'd1 << 30;
    for (int i = 1; i <= TableDepth; i++)
      exp_q30[i] = (exp_q30[i-1] * ratio + (64'd1 << 29)) >> 30;
  endfunction

  function automatic out_item_t predict_tick(input in_item_t tick);
    out_item_t       res;
    longint unsigned tau, x, p, idx, frac, ea, eb, diff, e30, e, alpha, g, dip;
    logic [39:0]     cur, prev;
    int unsigned     sh;
    logic [1:0]      act;
    bit              beat;
    res  = '0;
    beat = 1'b0;
    tau  = (cfg_model.decay_ms == 0) ? 1 : cfg_model.decay_ms;
    x    = (longint'(tick.dt_us) << 16) / (tau * 1000);
    if (x >= (64'd16 << 16)) begin
      alpha = GainOne;
    end else begin
      p     = x * TableDepth;
      idx   = p >> 20;
      frac  = p & 64'hF_FFFF;
      ea    = exp_q30[idx];
      eb    = exp_q30[idx + 1];
      diff  = (ea > eb) ? ea - eb : 0;
      e30   = ea - ((diff * frac) >> 20);
      e     = (e30 + (64'd1 << 13)) >> 14;
      if (e > GainOne) e = GainOne;
      alpha = GainOne - e;
    end
    g = env_gain;
    if (g > GainOne) g = GainOne;
    g += ((GainOne - g) * alpha) >> 16;
    if (g > GainOne) g = GainOne;
    env_gain = g[16:0];

    if (!tick.is_playing || tick.tempo_bpm < MinTempo || tick.dt_us == 0) begin
      hist_valid = 1'b0;
    end else begin
      cur  = tick.ppq_position ^ PosBias;
      prev = hist_pos ^ PosBias;
      case (cfg_model.grid_division)
        GridWhole:     sh = PosFrac + 2;
        GridHalf:      sh = PosFrac + 1;
        GridEighth:    sh = PosFrac - 1;
        GridSixteenth: sh = PosFrac - 2;
        default:       sh = PosFrac;
      endcase
      beat       = hist_valid && cur >= prev && (cur >> sh) > (prev >> sh);
      hist_pos   = tick.ppq_position;
      hist_valid = 1'b1;
    end

    if (beat) begin
      act = 2'(cfg_model.pattern_actions >> (2 * step_ctr));
      if (act == ActAdvance) begin
        res.morph_advance = 1'b1;
      end else if (act == ActJump) begin
        res.morph_jump = 1'b1;
        res.jump_slot  = 4'(cfg_model.pattern_targets >> (4 * step_ctr));
      end
      step_ctr = step_ctr + 4'd1;
      if (cfg_model.beat_mode == ModeTeleport) begin
        dip      = (cfg_model.dip_gain > GainOne) ? GainOne : cfg_model.dip_gain;
        env_gain = dip[16:0];
      end
    end
    res.step_index = step_ctr;
    res.gain       = env_gain;
    res.beat_fired = beat;
    return res;
  endfunction

  task automatic check_field(input string fname, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= 50)
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (expected_q.size() == 0) begin
        error_count++;
        $display("%0t unexpected result: expected none, actual %h", $time, out_data_o);
      end else begin
        want = expected_q.pop_front();
        check_field("step_index", want.step_index, out_data_o.step_index);
        check_field("gain", want.gain, out_data_o.gain);
        check_field("beat_fired", want.beat_fired, out_data_o.beat_fired);
        check_field("morph_advance", want.morph_advance, out_data_o.morph_advance);
        check_field("morph_jump", want.morph_jump, out_data_o.morph_jump);
        check_field("jump_slot", want.jump_slot, out_data_o.jump_slot);
        results_checked++;
        beats_seen    += want.beat_fired;
        advances_seen += want.morph_advance;
        jumps_seen    += want.morph_jump;
      end
    end
  end

  // hold valid across back-to-back ticks; drop it only for a sender gap
  task automatic send_tick(input in_item_t tick);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    do @(posedge clk); while (!in_ready_o);
    expected_q.push_back(predict_tick(tick));
    ticks_sent++;
  endtask

  task automatic play_tick(input longint pos, input logic [23:0] tempo,
                           input logic playing, input logic [19:0] dt);
    in_item_t tick;
    tick.ppq_position = 40'(pos);
    tick.tempo_bpm    = tempo;
    tick.is_playing   = playing;
    tick.dt_us        = dt;
    send_tick(tick);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CfgBeatMode:       cfg_model.beat_mode       = value[1:0];
      CfgGridDivision:   cfg_model.grid_division   = value[2:0];
      CfgDecayMs:        cfg_model.decay_ms        = value[15:0];
      CfgDipGain:        cfg_model.dip_gain        = value[16:0];
      CfgPatternActions: cfg_model.pattern_actions = value[31:0];
      CfgPatternTargets: cfg_model.pattern_targets = value;
      default: ;
    endcase
  endtask

  task automatic test_first_tick_and_beats();
    play_tick(0, MinTempo, 1'b1, 20'd1);
    play_tick(QN, TempoNormal, 1'b1, 20'd1);
    play_tick(QN + QN / 2, TempoNormal, 1'b1, 20'd500);
    play_tick(QN / 2, TempoNormal, 1'b1, 20'd500);
    play_tick(2 * QN, TempoNormal, 1'b1, 20'd500);
    drain_results();
  endtask

  task automatic test_stopped_transport();
    play_tick(3 * QN, TempoNormal, 1'b0, 20'd100);
    play_tick(4 * QN, TempoNormal, 1'b1, 20'd100);
    play_tick(5 * QN, MinTempo - 24'd1, 1'b1, 20'd100);
    play_tick(6 * QN, TempoNormal, 1'b1, 20'd100);
    play_tick(7 * QN, TempoNormal, 1'b1, 20'd0);
    play_tick(8 * QN, TempoNormal, 1'b1, 20'd100);
    play_tick(9 * QN, TempoNormal, 1'b1, 20'd100);
    drain_results();
  endtask

  task automatic test_pattern_actions();
    logic [1:0]  cycle_codes [4] = '{ActHold, ActAdvance, ActJump, ActSpare};
    logic [31:0] acts;
    logic [63:0] tgts;
    for (int s = 0; s < 16; s++) begin
      acts[2*s +: 2] = cycle_codes[s % 4];
      tgts[4*s +: 4] = 4'(15 - s);
    end
    write_reg(CfgPatternActions, 64'(acts));
    write_reg(CfgPatternTargets, tgts);
    // four beats in a row walk through every action code
    for (int n = 10; n < 14; n++) play_tick(n * QN, TempoNormal, 1'b1, 20'd200);
    drain_results();
  endtask

  task automatic test_grid_and_extremes();
    write_reg(CfgGridDivision, 64'(GridWhole));
    play_tick(-4 * QN, TempoNormal, 1'b1, 20'd50);
    play_tick(0, TempoNormal, 1'b1, 20'd50);
    drain_results();
    write_reg(CfgGridDivision, 64'(GridSixteenth));
    play_tick(QN / 4, TempoNormal, 1'b1, 20'd50);
    drain_results();
    write_reg(CfgGridDivision, 64'(GridSpare));
    play_tick(-PosMin - 1, 24'hFF_FFFF, 1'b1, 20'hF_FFFF);
    play_tick(PosMin, TempoNormal, 1'b1, 20'd1);
    drain_results();
  endtask

  task automatic test_teleport_and_decay();
    write_reg(CfgBeatMode, 64'(ModeTeleport));
    write_reg(CfgDipGain, 64'h1_FFFF);
    write_reg(CfgDecayMs, 64'd0);
    write_reg(CfgGridDivision, 64'(GridQuarter));
    play_tick(PosMin + QN, TempoNormal, 1'b1, 20'd1);
    drain_results();
    write_reg(CfgDipGain, 64'd0);
    play_tick(PosMin + 2 * QN, TempoNormal, 1'b1, 20'd1);
    play_tick(PosMin + 2 * QN + QN / 2, TempoNormal, 1'b1, 20'd1000);
    drain_results();
    write_reg(CfgBeatMode, 64'(ModeSpare));
    play_tick(PosMin + 3 * QN, TempoNormal, 1'b1, 20'd300);
    drain_results();
  endtask

  // mostly advancing transport runs, some rewinds, stops and raw noise
  function automatic in_item_t next_random_tick();
    in_item_t    tick;
    int unsigned kind;
    kind            = $urandom_range(99);
    tick.is_playing = 1'b1;
    tick.tempo_bpm  = 24'($urandom_range(MinTempo, 24'hFF_FFFF));
    tick.dt_us      = ($urandom_range(3) == 0) ? 20'($urandom_range(1, 20'hF_FFFF))
                                                : 20'($urandom_range(1, 4000));
    if (kind < 72) begin
      walk_pos = walk_pos + 40'($urandom_range(0, 1 << $urandom_range(8, 19)));
    end else if (kind < 80) begin
      walk_pos = walk_pos - 40'($urandom_range(0, 1 << 18));
    end else if (kind < 90) begin
      walk_pos = walk_pos + 40'($urandom_range(0, 1 << 16));
      case ($urandom_range(2))
        0:       tick.is_playing = 1'b0;
        1:       tick.tempo_bpm  = 24'($urandom_range(0, MinTempo - 1));
        default: tick.dt_us      = '0;
      endcase
    end else begin
      tick.ppq_position = 40'({$urandom, $urandom});
      tick.tempo_bpm    = 24'($urandom);
      tick.is_playing   = 1'($urandom);
      tick.dt_us        = 20'($urandom);
      if (kind >= 95) walk_pos = tick.ppq_position;
      return tick;
    end
    tick.ppq_position = walk_pos;
    return tick;
  endfunction

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input logic [1:0] mode, input logic [2:0] grid,
                                   input logic [15:0] decay, input logic [16:0] dip);
    write_reg(CfgBeatMode, 64'(mode));
    write_reg(CfgGridDivision, 64'(grid));
    write_reg(CfgDecayMs, 64'(decay));
    write_reg(CfgDipGain, 64'(dip));
    write_reg(CfgPatternActions, 64'($urandom));
    write_reg(CfgPatternTargets, {$urandom, $urandom});
    sender_idle_pct = idle_pct;
    rcv_stall_pct   = stall_pct;
    walk_pos        = 40'({$urandom, $urandom});
    repeat (150) send_tick(next_random_tick());
    drain_results();
  endtask

  initial begin
    fill_exp_table();
    cfg_model  = '{beat_mode: ModeSnap, grid_division: GridQuarter, decay_ms: 16'd100,
                   dip_gain: GainOne, pattern_actions: '0, pattern_targets: '0};
    hist_pos   = '0;
    hist_valid = 1'b0;
    step_ctr   = '0;
    env_gain   = GainOne;
    walk_pos   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_tick_and_beats();
    test_stopped_transport();
    test_pattern_actions();
    test_grid_and_extremes();
    test_teleport_and_decay();

    test_random_phase(0, 0, ModeTeleport, GridWhole, 16'd1, 17'd0);
    test_random_phase(45, 0, ModeGlide, GridSixteenth, 16'hFFFF, GainOne);
    test_random_phase(0, 45, ModeSpare, GridEighth, 16'($urandom_range(1, 200)),
                      17'($urandom));
    test_random_phase(21, 21, ModeTeleport, GridHalf, 16'($urandom), 17'($urandom));

    repeat (TailCycles) @(posedge clk);
    if (expected_q.size() != 0) begin
      error_count++;
      $display("%0t %0d results never arrived", $time, expected_q.size());
    end
    $display("Summary: %0d ticks, %0d results checked, %0d beats, %0d advances, %0d jumps",
             ticks_sent, results_checked, beats_seen, advances_seen, jumps_seen);
    $display("Summary: every mode and action, grids and decay/dip extremes, four idle mixes");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
